@@ rtl/core/bounded_deque_with_search_core_macros.svh @@
// Assertion macros shared by the deque checker
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BDQS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, disabled during reset
`define BDQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

@@ rtl/core/bdqs_pkg.sv @@
// Shared request codes, status codes and result types for the deque
package bdqs_pkg;

  typedef logic [2:0] req_t;
  typedef logic [1:0] status_t;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_CONTAINS   = 3'd4;
  localparam req_t REQ_REMOVE     = 3'd5;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_FULL     = 2'd1;
  localparam status_t STAT_EMPTY    = 2'd2;
  localparam status_t STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    status_t status;
    logic    found;
  } res_info_t;

endpackage

@@ rtl/core/bdqs_mem.sv @@
// Entry store: one write port, one registered read port
module bdqs_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/bdqs_ctrl.sv @@
// Sequencer: request decode, search walk, gap close and end-value fetch
module bdqs_ctrl #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [2:0]               in_req_type,
  input  logic [VALUE_WIDTH-1:0]   in_item_value,
  output logic                     busy,
  output logic                     res_valid,
  input  logic                     res_ready,
  output bdqs_pkg::res_info_t      res_info,
  output logic [CW-1:0]            res_count,
  output logic [VALUE_WIDTH-1:0]   res_front,
  output logic [VALUE_WIDTH-1:0]   res_back,
  output logic                     rd_en,
  output logic [IW-1:0]            rd_addr,
  input  logic [VALUE_WIDTH-1:0]   rd_data,
  output logic                     wr_en,
  output logic [IW-1:0]            wr_addr,
  output logic [VALUE_WIDTH-1:0]   wr_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_SHIFT  = 7'b0000100,
    S_RDF    = 7'b0001000,
    S_RDB    = 7'b0010000,
    S_CAP    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);

  // circular position of an offset from the front
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IW-1:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic [IW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            cmp_r, cmp_nxt;
  logic                     pend_r, pend_nxt;
  bdqs_pkg::req_t           req_r, req_nxt;
  logic [VALUE_WIDTH-1:0]   val_r, val_nxt;
  bdqs_pkg::status_t        status_r, status_nxt;
  logic                     found_r, found_nxt;
  logic [VALUE_WIDTH-1:0]   front_r, front_nxt;
  logic [VALUE_WIDTH-1:0]   back_r, back_nxt;

  logic [CW-1:0] count_m1;
  logic [CW-1:0] cmp_m1;
  logic          issue;
  logic          is_full;
  logic          is_empty;

  assign count_m1 = count_r - CW'(1);
  assign cmp_m1   = cmp_r - CW'(1);
  assign issue    = (idx_r < count_r);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    cmp_nxt    = cmp_r;
    pend_nxt   = pend_r;
    req_nxt    = req_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    wr_data    = in_item_value;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          val_nxt    = in_item_value;
          status_nxt = bdqs_pkg::STAT_OK;
          found_nxt  = 1'b0;
          case (in_req_type)
            bdqs_pkg::REQ_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = bdqs_pkg::STAT_FULL;
              end else begin
                head_nxt  = (head_r == '0) ? IW'(DEPTH - 1) : head_r - IW'(1);
                wr_en     = 1'b1;
                wr_addr   = head_nxt;
                count_nxt = count_r + CW'(1);
              end
            end
            bdqs_pkg::REQ_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = bdqs_pkg::STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = slot_of(head_r, count_r[IW-1:0]);
                count_nxt = count_r + CW'(1);
              end
            end
            bdqs_pkg::REQ_POP_FRONT: begin
              if (is_empty) begin
                status_nxt = bdqs_pkg::STAT_EMPTY;
              end else begin
                head_nxt  = slot_of(head_r, IW'(1));
                count_nxt = count_m1;
              end
            end
            bdqs_pkg::REQ_POP_BACK: begin
              if (is_empty) begin
                status_nxt = bdqs_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_m1;
              end
            end
            bdqs_pkg::REQ_CONTAINS, bdqs_pkg::REQ_REMOVE: begin
              if (is_empty) begin
                status_nxt = bdqs_pkg::STAT_EMPTY;
              end
            end
            default: ;
          endcase

          if ((in_req_type inside {bdqs_pkg::REQ_CONTAINS, bdqs_pkg::REQ_REMOVE})
              && !is_empty) begin
            state_nxt = S_SEARCH;
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
          end else if (count_nxt == '0) begin
            front_nxt = '0;
            back_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RDF;
          end
        end
      end

      S_SEARCH: begin
        // reads run one ahead of the compare
        if (issue) begin
          rd_en   = 1'b1;
          rd_addr = slot_of(head_r, idx_r[IW-1:0]);
          idx_nxt = idx_r + CW'(1);
        end
        pend_nxt = issue;
        cmp_nxt  = idx_r;
        if (pend_r) begin
          if (rd_data == val_r) begin
            found_nxt = 1'b1;
            pend_nxt  = 1'b0;
            if (req_r == bdqs_pkg::REQ_REMOVE) begin
              state_nxt = S_SHIFT;
              idx_nxt   = cmp_r + CW'(1);
            end else begin
              state_nxt = S_RDF;
            end
          end else if (cmp_r == count_m1) begin
            status_nxt = bdqs_pkg::STAT_NOTFOUND;
            pend_nxt   = 1'b0;
            state_nxt  = S_RDF;
          end
        end
      end

      S_SHIFT: begin
        // move each later entry one place toward the front
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = slot_of(head_r, cmp_m1[IW-1:0]);
          wr_data = rd_data;
        end
        if (issue) begin
          rd_en   = 1'b1;
          rd_addr = slot_of(head_r, idx_r[IW-1:0]);
          idx_nxt = idx_r + CW'(1);
        end
        pend_nxt = issue;
        cmp_nxt  = idx_r;
        if (!pend_r && !issue) begin
          count_nxt = count_m1;
          if (count_m1 == '0) begin
            front_nxt = '0;
            back_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RDF;
          end
        end
      end

      S_RDF: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_RDB;
      end

      S_RDB: begin
        rd_en     = 1'b1;
        rd_addr   = slot_of(head_r, count_m1[IW-1:0]);
        front_nxt = rd_data;
        state_nxt = S_CAP;
      end

      S_CAP: begin
        back_nxt  = rd_data;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cmp_r    <= cmp_nxt;
    req_r    <= req_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res_info.status = status_r;
  assign res_info.found  = found_r;
  assign res_count       = count_r;
  assign res_front       = front_r;
  assign res_back        = back_r;

endmodule

@@ rtl/core/bounded_deque_with_search_core.sv @@
// Top level of the bounded deque with search: sequencer, entry store, result register.
// Push, pop, unused codes: the front and back values are fetched (S_RDF, S_RDB, S_CAP) before the
// result, or zeroed if the deque ends empty. Contains and remove search from the front; the search
// and remove's gap close share one walk of the entry store's single read port, one entry per cycle.
// One item in flight: the next input transfer comes the cycle after the result is registered.
// Synchronous reset (rst_n low) empties the deque and drops any held result, not the store.
module bounded_deque_with_search_core #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_req_type,
  input  logic signed [VALUE_WIDTH-1:0]   in_item_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic                            out_found,
  output logic [$clog2(DEPTH+1)-1:0]      out_entry_count,
  output logic signed [VALUE_WIDTH-1:0]   out_front_value,
  output logic signed [VALUE_WIDTH-1:0]   out_back_value
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer <-> store
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // sequencer -> result register
  logic                   busy;
  logic                   res_valid;
  logic                   res_ready;
  bdqs_pkg::res_info_t    res_info;
  logic [CW-1:0]          res_count;
  logic [VALUE_WIDTH-1:0] res_front;
  logic [VALUE_WIDTH-1:0] res_back;

  // result register: decouples the sequencer from a stalled receiver
  logic                   out_valid_r, out_valid_nxt;
  bdqs_pkg::res_info_t    out_info_r;
  logic [CW-1:0]          out_count_r;
  logic [VALUE_WIDTH-1:0] out_front_r;
  logic [VALUE_WIDTH-1:0] out_back_r;
  logic                   res_load;

  // only take a request while the sequencer is idle; one in flight at a time
  assign in_stall = busy;

  bdqs_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_req_type   (in_req_type),
    .in_item_value (in_item_value),
    .busy          (busy),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_info      (res_info),
    .res_count     (res_count),
    .res_front     (res_front),
    .res_back      (res_back),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  bdqs_mem #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // register is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;
  assign res_load  = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only moves on a load, so it holds while stalled
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_info_r  <= res_info;
      out_count_r <= res_count;
      out_front_r <= res_front;
      out_back_r  <= res_back;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_info_r.status;
  assign out_found       = out_info_r.found;
  assign out_entry_count = out_count_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;

endmodule

@@ rtl/core/bdqs_checker.sv @@
// Port-level checker for the deque core, with its bind
`include "bounded_deque_with_search_core_macros.svh"

module bdqs_checker #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [1:0]             out_status,
  input logic                   out_found,
  input logic [CW-1:0]          out_entry_count,
  input logic [VALUE_WIDTH-1:0] out_front_value,
  input logic [VALUE_WIDTH-1:0] out_back_value
);

  // a stalled result stays valid, with its status, count and front value stable
  `BDQS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_entry_count) && $stable(out_front_value))

  // empty deque shows zero at both ends
  `BDQS_ASSERT_IMPL(a_empty_ends, clk, rst_n, out_valid && (out_entry_count == '0), (out_front_value == '0) && (out_back_value == '0))

  // full is only reported at capacity
  `BDQS_ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && (out_status == bdqs_pkg::STAT_FULL), out_entry_count == CW'(DEPTH))

  // a match always comes with an ok status
  `BDQS_ASSERT_IMPL(a_found_ok, clk, rst_n, out_valid && out_found, out_status == bdqs_pkg::STAT_OK)

  // empty status means nothing stored and nothing found
  `BDQS_ASSERT_IMPL(a_empty_status, clk, rst_n, out_valid && (out_status == bdqs_pkg::STAT_EMPTY), (out_entry_count == '0) && !out_found)

endmodule

bind bounded_deque_with_search_core bdqs_checker #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_bdqs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_entry_count (out_entry_count),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value)
);

@@ verif/tb_bounded_deque_with_search_core.sv @@
// Self-checking testbench for the bounded deque with search core.
module tb_bounded_deque_with_search_core;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  // Random traffic is split into phases, each with its own request mix.
  localparam int PHASES      = 21;
  localparam int PHASE_ITEMS = 50;

  // Mixes for the random phases: mostly pushing, mostly popping, or balanced.
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_SEARCH} traffic_mix_t;

  typedef struct {
    bdqs_pkg::status_t       status;
    logic                    found;
    logic [COUNT_WIDTH-1:0]  entry_count;
    logic [VALUE_WIDTH-1:0]  front_value;
    logic [VALUE_WIDTH-1:0]  back_value;
  } deque_result_t;

  // Shadow copy of the deque. Each accepted request updates the copy and
  // queues the result that the core must return for it; results come back
  // in request order, one per request.
  class deque_shadow;
    logic [VALUE_WIDTH-1:0] slots [DEPTH];
    logic [3:0]             head;
    logic [COUNT_WIDTH-1:0] count;
    deque_result_t          awaited_results [$];
    int unsigned            mismatches;

    function new();
      head       = '0;
      count      = '0;
      mismatches = 0;
      foreach (slots[k]) slots[k] = '0;
    endfunction

    // Applies one accepted request and queues its expected result.
    function void note_request(bdqs_pkg::req_t req, logic [VALUE_WIDTH-1:0] value);
      deque_result_t res;
      int            hit;
      logic [3:0]    idx;
      res.status = bdqs_pkg::STAT_OK;
      res.found  = 1'b0;
      case (req)
        bdqs_pkg::REQ_PUSH_FRONT: begin
          if (count == DEPTH) begin
            res.status = bdqs_pkg::STAT_FULL;
          end else begin
            head        = head - 4'd1;
            slots[head] = value;
            count       = count + 1'b1;
          end
        end
        bdqs_pkg::REQ_PUSH_BACK: begin
          if (count == DEPTH) begin
            res.status = bdqs_pkg::STAT_FULL;
          end else begin
            idx        = head + count[3:0];
            slots[idx] = value;
            count      = count + 1'b1;
          end
        end
        bdqs_pkg::REQ_POP_FRONT: begin
          if (count == 0) begin
            res.status = bdqs_pkg::STAT_EMPTY;
          end else begin
            head  = head + 4'd1;
            count = count - 1'b1;
          end
        end
        bdqs_pkg::REQ_POP_BACK: begin
          if (count == 0) res.status = bdqs_pkg::STAT_EMPTY;
          else count = count - 1'b1;
        end
        bdqs_pkg::REQ_CONTAINS, bdqs_pkg::REQ_REMOVE: begin
          if (count == 0) begin
            res.status = bdqs_pkg::STAT_EMPTY;
          end else begin
            hit = -1;
            for (int i = 0; i < count; i++) begin
              idx = head + i[3:0];
              if (hit < 0 && slots[idx] == value) hit = i;
            end
            if (hit < 0) begin
              res.status = bdqs_pkg::STAT_NOTFOUND;
            end else begin
              res.found = 1'b1;
              if (req == bdqs_pkg::REQ_REMOVE) begin
                // later entries close up towards the front
                for (int i = hit; i + 1 < count; i++) begin
                  idx        = head + i[3:0];
                  slots[idx] = slots[idx + 4'd1];
                end
                count = count - 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      res.entry_count = count;
      if (count == 0) begin
        res.front_value = '0;
        res.back_value  = '0;
      end else begin
        idx             = head + count[3:0] - 4'd1;
        res.front_value = slots[head];
        res.back_value  = slots[idx];
      end
      awaited_results.push_back(res);
    endfunction

    // Compares one returned result with the oldest one awaited.
    function void check_result(bdqs_pkg::status_t status, logic found,
                               logic [COUNT_WIDTH-1:0] entry_count,
                               logic [VALUE_WIDTH-1:0] front_value,
                               logic [VALUE_WIDTH-1:0] back_value);
      deque_result_t exp;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
        return;
      end
      exp = awaited_results.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        mismatches++;
      end
      if (found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, found);
        mismatches++;
      end
      if (entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, entry_count);
        mismatches++;
      end
      if (front_value !== exp.front_value) begin
        $error("front_value: expected %0d, got %0d",
               $signed(exp.front_value), $signed(front_value));
        mismatches++;
      end
      if (back_value !== exp.back_value) begin
        $error("back_value: expected %0d, got %0d",
               $signed(exp.back_value), $signed(back_value));
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [2:0]                    in_req_type;
  logic signed [VALUE_WIDTH-1:0] in_item_value;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    out_status;
  logic                          out_found;
  logic [COUNT_WIDTH-1:0]        out_entry_count;
  logic signed [VALUE_WIDTH-1:0] out_front_value;
  logic signed [VALUE_WIDTH-1:0] out_back_value;

  deque_shadow shadow;

  bounded_deque_with_search_core #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_count (out_entry_count),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value)
  );

  // 10 time unit period; rising edges at 5, 15, ...
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Small pool of values so that searches and removals hit often and
  // duplicates build up; the extremes of the signed range are in it.
  function automatic logic [VALUE_WIDTH-1:0] pool_value(int unsigned k);
    case (k % 8)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h5A5A_A5A5;
      6:       return 32'hFFFF_FF9C;
      default: return 32'h0000_0007;
    endcase
  endfunction

  // Mostly pool values, the rest fully random so every bit toggles.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    if ($urandom_range(0, 99) < 65) return pool_value($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic bdqs_pkg::req_t pick_request(traffic_mix_t mix);
    int unsigned r;
    int unsigned push_pct;
    int unsigned pop_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin push_pct = 65; pop_pct = 15; end
      MIX_DRAIN: begin push_pct = 20; pop_pct = 55; end
      default:   begin push_pct = 35; pop_pct = 30; end
    endcase
    if (r < 3) return bdqs_pkg::req_t'($urandom_range(6, 7));   // unused codes, ignored
    if (r < 3 + push_pct)
      return $urandom_range(0, 1) ? bdqs_pkg::REQ_PUSH_BACK : bdqs_pkg::REQ_PUSH_FRONT;
    if (r < 3 + push_pct + pop_pct)
      return $urandom_range(0, 1) ? bdqs_pkg::REQ_POP_BACK : bdqs_pkg::REQ_POP_FRONT;
    return $urandom_range(0, 1) ? bdqs_pkg::REQ_REMOVE : bdqs_pkg::REQ_CONTAINS;
  endfunction

  // Presents one request at the falling edge and holds it until the
  // transfer happens at a rising edge with in_stall low.
  task automatic send_request(bdqs_pkg::req_t req, logic [VALUE_WIDTH-1:0] value);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_item_value <= value;
    do @(posedge clk); while (in_stall);
    shadow.note_request(req, value);
  endtask

  // Idle cycles on the request side: mostly none or short, a few long.
  task automatic request_gap(bit quiet);
    int unsigned r;
    int unsigned len;
    if (quiet) return;
    r = $urandom_range(0, 99);
    if (r < 55)      len = 0;
    else if (r < 90) len = $urandom_range(1, 3);
    else             len = $urandom_range(6, 30);
    if (len == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (len - 1) @(negedge clk);
  endtask

  task automatic send_and_idle(bdqs_pkg::req_t req, logic [VALUE_WIDTH-1:0] value,
                               bit quiet);
    send_request(req, value);
    request_gap(quiet);
  endtask

  // Result side back-pressure: short bursts of stall, the odd long one,
  // and stretches of free flow in between.
  initial begin
    int unsigned r;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r >= 60) begin
        @(negedge clk);
        out_stall <= 1'b1;
        if (r < 90) repeat ($urandom_range(0, 2)) @(negedge clk);
        else        repeat ($urandom_range(5, 40)) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 120)) @(negedge clk);
      else                           repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // Every result transfer is checked against the oldest awaited result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      shadow.check_result(out_status, out_found, out_entry_count,
                          out_front_value, out_back_value);
  end

  initial begin
    traffic_mix_t mix;
    bit           quiet;
    shadow        = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = bdqs_pkg::REQ_PUSH_FRONT;
    in_item_value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every pop and search request on an empty deque, the unused codes, a fill
    // past full with the extremes and duplicates, then hits and misses.
    send_and_idle(bdqs_pkg::REQ_POP_FRONT, 32'h0, 1'b0);
    send_and_idle(bdqs_pkg::REQ_POP_BACK, 32'h0, 1'b0);
    send_and_idle(bdqs_pkg::REQ_CONTAINS, 32'h0, 1'b0);
    send_and_idle(bdqs_pkg::REQ_REMOVE, 32'h0, 1'b0);
    send_and_idle(bdqs_pkg::req_t'(3'd6), 32'hFFFF_FFFF, 1'b0);
    send_and_idle(bdqs_pkg::req_t'(3'd7), 32'h8000_0000, 1'b0);
    for (int i = 0; i < DEPTH; i++)
      send_and_idle(i[0] ? bdqs_pkg::REQ_PUSH_FRONT : bdqs_pkg::REQ_PUSH_BACK,
                    pool_value(i), 1'b0);
    send_and_idle(bdqs_pkg::REQ_PUSH_FRONT, 32'h1234_5678, 1'b0);    // full: rejected
    send_and_idle(bdqs_pkg::REQ_PUSH_BACK, 32'h1234_5678, 1'b0);     // full: rejected
    send_and_idle(bdqs_pkg::REQ_CONTAINS, 32'h7FFF_FFFF, 1'b0);
    send_and_idle(bdqs_pkg::REQ_CONTAINS, 32'h1234_5678, 1'b0);      // missing
    send_and_idle(bdqs_pkg::REQ_REMOVE, 32'h8000_0000, 1'b0);        // first of two copies
    send_and_idle(bdqs_pkg::REQ_REMOVE, 32'h1234_5678, 1'b0);        // missing
    send_and_idle(bdqs_pkg::REQ_POP_FRONT, 32'h0, 1'b0);
    send_and_idle(bdqs_pkg::REQ_POP_BACK, 32'h0, 1'b0);

    // Random phases; about one in four runs with no idle cycles at all.
    for (int p = 0; p < PHASES; p++) begin
      mix   = traffic_mix_t'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_and_idle(pick_request(mix), pick_value(), quiet);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every awaited result, then allow for the longest
    // removal walk before looking for stray transfers.
    while (shadow.awaited_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #6_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
